### hw/rtl/epp_pkg.sv
// Package for the elevation piecewise polynomial position unit.
// Holds widths, field codes, section bounds, sequencer states and the
// accumulator saturation helper. No dependencies.
package epp_pkg;

  // Table geometry
  localparam int SECTION_COUNT      = 5;
  localparam int TERM_COUNT_DEFAULT = 4;

  // Field widths
  localparam int ELEV_W     = 16;
  localparam int PROFILE_W  = 3;
  localparam int SEC_W      = 3;
  localparam int TERM_IDX_W = 2;
  localparam int COEF_W     = 32;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 32;

  // Internal datapath widths
  localparam int EL_W       = 15;  // clamped elevation, Q7.8, always positive
  localparam int ACC_W      = 48;  // Horner accumulator, signed Q32.16
  localparam int HALF_W     = 24;  // accumulator split for the shared multiplier
  localparam int WIDE_W     = 60;  // headroom for sums before saturation
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 33;
  localparam int MUL_P_W    = 58;
  localparam int POS_WIDE_W = 50;  // signed step value before the clamp

  // Input modes
  localparam logic MODE_EVAL = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Profiles; codes above PROFILE_PARK behave as park
  localparam logic [PROFILE_W-1:0] PROFILE_SHAPED          = 3'd0;
  localparam logic [PROFILE_W-1:0] PROFILE_SHAPED_FIXED    = 3'd1;
  localparam logic [PROFILE_W-1:0] PROFILE_PARABOLIC       = 3'd2;
  localparam logic [PROFILE_W-1:0] PROFILE_PARABOLIC_FIXED = 3'd3;
  localparam logic [PROFILE_W-1:0] PROFILE_PARK            = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PARABOLIC_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MM_TO_STEP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT      = 2'd3;

  localparam logic [CFG_W-1:0] MM_TO_STEP_RESET = 32'd65536;

  // Elevations in Q7.8 degrees
  localparam logic [EL_W-1:0] EL_MIN   = 15'd3840;   // 15 deg
  localparam logic [EL_W-1:0] EL_MAX   = 15'd23040;  // 90 deg
  localparam logic [EL_W-1:0] EL_FIXED = 15'd11520;  // 45 deg

  // Section lower bounds, 15 deg apart; entry SECTION_COUNT is the top end
  localparam logic [SECTION_COUNT:0][EL_W-1:0] SECTION_BOUND = {
    15'd23040, 15'd19200, 15'd15360, 15'd11520, 15'd7680, 15'd3840
  };

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MHI,
    ST_MLO,
    ST_ADD,
    ST_OFFS,
    ST_ABS,
    ST_SLO,
    ST_SHI,
    ST_SSUM,
    ST_OUT
  } epp_state_e;

  // Saturate a wide signed value to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[WIDE_W-1:ACC_W-1] == '0 || v[WIDE_W-1:ACC_W-1] == '1) begin
      r = v[ACC_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hw/rtl/epp_if.sv
// Handshake channel interfaces: input items, result items and config writes.
// Depends on epp_pkg for the field widths.

interface epp_in_if import epp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic signed [ELEV_W-1:0]    elevation;
  logic [PROFILE_W-1:0]        profile;
  logic [SEC_W-1:0]            section_select;
  logic [TERM_IDX_W-1:0]       term_index;
  logic signed [COEF_W-1:0]    coefficient_value;

  modport source (
    output valid, mode, elevation, profile, section_select, term_index, coefficient_value,
    input  ready
  );
  modport sink (
    input  valid, mode, elevation, profile, section_select, term_index, coefficient_value,
    output ready
  );
endinterface

interface epp_out_if import epp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  position_steps;
  logic                     coefficients_missing;

  modport source (output valid, position_steps, coefficients_missing, input ready);
  modport sink   (input  valid, position_steps, coefficients_missing, output ready);
endinterface

interface epp_cfg_if import epp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

### hw/rtl/epp_mul.sv
// Shared signed multiplier with a registered product.
// Used for both the Horner steps and the mm-to-step scaling. Depends on epp_pkg.
module epp_mul import epp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [MUL_A_W-1:0]   a_i,
  input  logic signed [MUL_B_W-1:0]   b_i,
  output logic signed [MUL_P_W-1:0]   p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  // Product is registered and available in the cycle after the operands are issued
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

### hw/rtl/epp_coef_table.sv
// Coefficient table: one row of TERM_COUNT words per elevation section.
// Flip-flop storage, cleared at reset, one write and one read port. Depends on epp_pkg.
module epp_coef_table import epp_pkg::*; #(
  parameter int TERM_COUNT = TERM_COUNT_DEFAULT,
  localparam int DEPTH     = SECTION_COUNT * TERM_COUNT,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic signed [COEF_W-1:0]  wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic signed [COEF_W-1:0]  rdata_o
);

  logic signed [COEF_W-1:0] coef_q [DEPTH];

  // Terms never loaded read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        coef_q[i] <= '0;
      end
    end else if (we_i) begin
      coef_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = coef_q[raddr_i];

endmodule

### hw/rtl/elevation_piecewise_poly_position_unit.sv
// Elevation to actuator step target. A load transaction writes one coefficient
// into a table of five 15-degree elevation sections. An evaluate transaction
// clamps or fixes the elevation, picks its section, runs Horner's method over
// the section's TERM_COUNT coefficients, optionally adds the parabolic offset,
// scales to steps and clamps to the step limits. All multiplications share
// one 25x33 multiplier: each Horner step issues two partial products and then
// an add, and the scaling takes sign and magnitude, two partial products and
// a sum. Park or missing coefficients go straight to the output state. The
// input is not ready while an item is in work, so a new item is taken only
// after the last one is handed to the output register; the result sits there
// until taken. Configuration writes are always ready and must only happen
// while the block is idle.
// Depends on epp_pkg, epp_if, epp_mul and epp_coef_table.
module elevation_piecewise_poly_position_unit import epp_pkg::*; #(
  parameter int TERM_COUNT = TERM_COUNT_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  epp_in_if.sink      in_i,
  epp_out_if.source   out_o,
  epp_cfg_if.sink     cfg_i
);

  localparam int TAB_AW = $clog2(SECTION_COUNT * TERM_COUNT);
  localparam int TERM_W = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;
  localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(TERM_COUNT - 1);

  epp_state_e state_q, state_d;

  // Configuration registers
  logic signed [CFG_W-1:0] offset_q;
  logic [CFG_W-1:0]        scale_q;
  logic signed [CFG_W-1:0] lower_q;
  logic signed [CFG_W-1:0] upper_q;

  // Control and datapath registers
  logic                        loaded_q, loaded_d;
  logic [EL_W-1:0]             el_q, el_d;
  logic [SEC_W-1:0]            sec_q, sec_d;
  logic [TERM_W-1:0]           k_q, k_d;
  logic                        parab_q, parab_d;
  logic                        zero_q, zero_d;
  logic                        miss_q, miss_d;
  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic [ACC_W-1:0]            mag_q, mag_d;
  logic                        neg_q, neg_d;
  logic signed [MUL_P_W-1:0]   keep_q, keep_d;
  logic signed [POS_WIDE_W-1:0] pos_q, pos_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic signed [POS_W-1:0]     out_pos_q, out_pos_d;
  logic                        out_miss_q, out_miss_d;

  // Shared multiplier and table signals
  logic                        mul_en;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [MUL_P_W-1:0]   mul_p;
  logic                        tab_we;
  logic [TAB_AW-1:0]           tab_waddr;
  logic [TAB_AW-1:0]           tab_raddr;
  logic signed [COEF_W-1:0]    tab_rdata;

  logic                        in_fire;
  logic                        load_ok;
  logic                        eval_prof;
  logic                        fixed_prof;
  logic [EL_W-1:0]             el_sel;
  logic [SEC_W-1:0]            sec_sel;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Load address check and table write
  assign load_ok   = (int'(in_i.section_select) < SECTION_COUNT) &&
                     (int'(in_i.term_index) < TERM_COUNT);
  assign tab_waddr = TAB_AW'(int'(in_i.section_select) * TERM_COUNT + int'(in_i.term_index));
  assign tab_we    = in_fire && (in_i.mode == MODE_LOAD) && load_ok;
  assign tab_raddr = TAB_AW'(int'(sec_q) * TERM_COUNT + int'(k_q));

  // Profile decode
  assign eval_prof  = (in_i.profile < PROFILE_PARK);
  assign fixed_prof = (in_i.profile == PROFILE_SHAPED_FIXED) ||
                      (in_i.profile == PROFILE_PARABOLIC_FIXED);

  // Elevation used and its section
  always_comb begin
    if (fixed_prof) begin
      el_sel = EL_FIXED;
    end else if (in_i.elevation < $signed({1'b0, EL_MIN})) begin
      el_sel = EL_MIN;
    end else if (in_i.elevation > $signed({1'b0, EL_MAX})) begin
      el_sel = EL_MAX;
    end else begin
      el_sel = in_i.elevation[EL_W-1:0];
    end
    sec_sel = '0;
    for (int k = 1; k < SECTION_COUNT; k++) begin
      if (el_sel >= SECTION_BOUND[k]) begin
        sec_sel = SEC_W'(k);
      end
    end
  end

  epp_coef_table #(
    .TERM_COUNT (TERM_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (in_i.coefficient_value),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  epp_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Sequencer: next state, datapath updates, multiplier operands
  always_comb begin
    logic signed [WIDE_W-1:0]     hi_term;
    logic signed [WIDE_W-1:0]     lo_term;
    logic signed [ACC_W-1:0]      step;
    logic [MUL_P_W-2:0]           scl_sum;
    logic [POS_WIDE_W-2:0]        steps_mag;
    logic signed [POS_WIDE_W-1:0] lim_lo;
    logic signed [POS_WIDE_W-1:0] lim_hi;
    logic signed [POS_W-1:0]      clamped;

    state_d     = state_q;
    loaded_d    = loaded_q;
    el_d        = el_q;
    sec_d       = sec_q;
    k_d         = k_q;
    parab_d     = parab_q;
    zero_d      = zero_q;
    miss_d      = miss_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    keep_d      = keep_q;
    pos_d       = pos_q;
    out_pos_d   = out_pos_q;
    out_miss_d  = out_miss_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    hi_term   = $signed({keep_q[43:0], 16'b0});
    lo_term   = $signed({12'b0, mul_p[ACC_W+7:8]});
    step      = sat_acc(hi_term + lo_term);
    scl_sum   = {1'b0, mul_p[MUL_P_W-3:0]} + {25'b0, keep_q[MUL_P_W-3:HALF_W]};
    steps_mag = scl_sum[MUL_P_W-2:8];
    lim_lo    = POS_WIDE_W'(lower_q);
    lim_hi    = POS_WIDE_W'(upper_q);
    if (pos_q < lim_lo) begin
      clamped = lower_q;
    end else if (pos_q > lim_hi) begin
      clamped = upper_q;
    end else begin
      clamped = pos_q[POS_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.mode == MODE_LOAD) begin
            if (load_ok) begin
              loaded_d = 1'b1;
            end
          end else if (!eval_prof) begin
            zero_d  = 1'b1;
            miss_d  = 1'b0;
            state_d = ST_OUT;
          end else if (!loaded_q) begin
            zero_d  = 1'b1;
            miss_d  = 1'b1;
            state_d = ST_OUT;
          end else begin
            el_d    = el_sel;
            sec_d   = sec_sel;
            k_d     = TERM_LAST;
            parab_d = (in_i.profile == PROFILE_PARABOLIC) ||
                      (in_i.profile == PROFILE_PARABOLIC_FIXED);
            zero_d  = 1'b0;
            miss_d  = 1'b0;
            state_d = ST_INIT;
          end
        end
      end
      // Highest term seeds the accumulator
      ST_INIT: begin
        acc_d = ACC_W'(tab_rdata);
        if (TERM_COUNT == 1) begin
          state_d = ST_OFFS;
        end else begin
          k_d     = k_q - TERM_W'(1);
          state_d = ST_MHI;
        end
      end
      // Upper half of acc times elevation
      ST_MHI: begin
        mul_en  = 1'b1;
        mul_a   = {acc_q[ACC_W-1], acc_q[ACC_W-1:HALF_W]};
        mul_b   = {18'b0, el_q};
        state_d = ST_MLO;
      end
      // Lower half of acc times elevation, keep the upper product
      ST_MLO: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, acc_q[HALF_W-1:0]};
        mul_b   = {18'b0, el_q};
        keep_d  = mul_p;
        state_d = ST_ADD;
      end
      // floor(acc*el/256) saturated, plus this term's coefficient
      ST_ADD: begin
        acc_d = sat_acc(WIDE_W'(step) + WIDE_W'(tab_rdata));
        if (k_q == '0) begin
          state_d = ST_OFFS;
        end else begin
          k_d     = k_q - TERM_W'(1);
          state_d = ST_MHI;
        end
      end
      ST_OFFS: begin
        if (parab_q) begin
          acc_d = sat_acc(WIDE_W'(acc_q) + WIDE_W'(offset_q));
        end
        state_d = ST_ABS;
      end
      // Sign and magnitude for truncation toward zero
      ST_ABS: begin
        neg_d   = acc_q[ACC_W-1];
        mag_d   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
        state_d = ST_SLO;
      end
      ST_SLO: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, mag_q[HALF_W-1:0]};
        mul_b   = {1'b0, scale_q};
        state_d = ST_SHI;
      end
      ST_SHI: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, mag_q[ACC_W-1:HALF_W]};
        mul_b   = {1'b0, scale_q};
        keep_d  = mul_p;
        state_d = ST_SSUM;
      end
      // (hi + lo/2^24) / 2^8 gives the product over 2^32
      ST_SSUM: begin
        pos_d   = neg_q ? -$signed({1'b0, steps_mag}) : $signed({1'b0, steps_mag});
        state_d = ST_OUT;
      end
      // Clamp and hand over once the output register is free
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = zero_q ? '0 : clamped;
          out_miss_d  = miss_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    el_q       <= el_d;
    sec_q      <= sec_d;
    k_q        <= k_d;
    parab_q    <= parab_d;
    zero_q     <= zero_d;
    miss_q     <= miss_d;
    acc_q      <= acc_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    keep_q     <= keep_d;
    pos_q      <= pos_d;
    out_pos_q  <= out_pos_d;
    out_miss_q <= out_miss_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      scale_q  <= MM_TO_STEP_RESET;
      lower_q  <= '0;
      upper_q  <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_PARABOLIC_OFFSET: offset_q <= $signed(cfg_i.data);
        CFG_MM_TO_STEP:       scale_q  <= cfg_i.data;
        CFG_LOWER_LIMIT:      lower_q  <= $signed(cfg_i.data);
        CFG_UPPER_LIMIT:      upper_q  <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.position_steps       = out_pos_q;
  assign out_o.coefficients_missing = out_miss_q;

endmodule
